// File: rtl/ils_pkg.sv
package ils_pkg;

  localparam int CAPACITY = 64;
  localparam int ADDR_W   = $clog2(CAPACITY);
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int POS_W    = 7;
  localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;

  localparam logic [2:0] OP_READ     = 3'd0;
  localparam logic [2:0] OP_INS_HEAD = 3'd1;
  localparam logic [2:0] OP_INS_TAIL = 3'd2;
  localparam logic [2:0] OP_INS_AT   = 3'd3;
  localparam logic [2:0] OP_DELETE   = 3'd4;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic signed [31:0] READ_MISS = -32'sd1;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_RDWAIT = 5'b00010,
    S_SHIFT  = 5'b00100,
    S_DRAIN  = 5'b01000,
    S_PUT    = 5'b10000
  } state_t;

endpackage

// File: rtl/indexed_list_store_unit.sv
// Channel   Ports                            Handshake
// request   func, position, value            start && !busy
// result    read_value, status, list_length  done, one cycle
//
// A read passes through S_RDWAIT; an ignored or refused request finishes in S_IDLE. An insert
// at p < count runs S_SHIFT, S_DRAIN and S_PUT, one at the end S_PUT alone; a delete at
// p < count - 1 runs S_SHIFT and S_DRAIN, one of the last entry ends in S_IDLE. Moves go
// through the entry memory one entry per cycle, with one read and one write in each cycle.
// Reset clears the entry count; the entry memory is not cleared.
// The receiver cannot stall: done is shown for exactly one cycle per result.
module indexed_list_store_unit (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  output logic                    busy,
  input  logic [2:0]              func,
  input  logic [6:0]              position,
  input  logic signed [31:0]      value,
  output logic                    done,
  output logic signed [31:0]      read_value,
  output logic [1:0]              status,
  output logic [6:0]              list_length
);

  ils_pkg::state_t state;

  logic signed [31:0]              mem [ils_pkg::CAPACITY];
  logic signed [31:0]              rdata;
  logic [ils_pkg::ADDR_W-1:0]      rd_addr;
  logic [ils_pkg::ADDR_W-1:0]      rptr;
  logic [ils_pkg::ADDR_W-1:0]      last;
  logic [ils_pkg::ADDR_W-1:0]      wr_addr;
  logic [ils_pkg::ADDR_W-1:0]      pos_reg;
  logic signed [31:0]              value_reg;
  logic                            is_ins;
  logic                            wr_pend;
  logic [ils_pkg::CNT_W-1:0]       count;

  logic                            accept;
  logic [ils_pkg::CMP_W-1:0]       pos_ext;
  logic [ils_pkg::CMP_W-1:0]       cnt_ext;
  logic [ils_pkg::CMP_W-1:0]       ins_pos;
  logic                            ins_ok;
  logic                            full;

  assign busy    = (state != ils_pkg::S_IDLE);
  assign accept  = start && !busy;
  assign pos_ext = ils_pkg::CMP_W'(position);
  assign cnt_ext = ils_pkg::CMP_W'(count);
  assign full    = (cnt_ext == ils_pkg::CMP_W'(ils_pkg::CAPACITY));
  assign list_length = cnt_ext[6:0];

  always_comb begin
    case (func)
      ils_pkg::OP_INS_HEAD: begin
        ins_pos = '0;
        ins_ok  = 1'b1;
      end
      ils_pkg::OP_INS_TAIL: begin
        ins_pos = cnt_ext;
        ins_ok  = 1'b1;
      end
      default: begin
        ins_pos = pos_ext;
        ins_ok  = (pos_ext <= cnt_ext);
      end
    endcase
  end

  always_comb begin
    if (state == ils_pkg::S_SHIFT) begin
      rd_addr = rptr;
    end else begin
      rd_addr = ils_pkg::ADDR_W'(position);
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[rd_addr];
    if (wr_pend) begin
      mem[wr_addr] <= rdata;
    end else if (state == ils_pkg::S_PUT) begin
      mem[pos_reg] <= value_reg;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ils_pkg::S_IDLE;
      done    <= 1'b0;
      wr_pend <= 1'b0;
      count   <= '0;
    end else begin
      done    <= 1'b0;
      wr_pend <= (state == ils_pkg::S_SHIFT);
      case (state)
        ils_pkg::S_IDLE: begin
          if (accept) begin
            read_value <= '0;
            status     <= ils_pkg::ST_DONE;
            case (func)
              ils_pkg::OP_READ: begin
                if (pos_ext < cnt_ext) begin
                  state <= ils_pkg::S_RDWAIT;
                end else begin
                  read_value <= ils_pkg::READ_MISS;
                  status     <= ils_pkg::ST_RANGE;
                  done       <= 1'b1;
                end
              end
              ils_pkg::OP_INS_HEAD, ils_pkg::OP_INS_TAIL, ils_pkg::OP_INS_AT: begin
                if (!ins_ok) begin
                  status <= ils_pkg::ST_RANGE;
                  done   <= 1'b1;
                end else if (full) begin
                  status <= ils_pkg::ST_FULL;
                  done   <= 1'b1;
                end else begin
                  pos_reg   <= ils_pkg::ADDR_W'(ins_pos);
                  value_reg <= value;
                  is_ins    <= 1'b1;
                  if (ins_pos == cnt_ext) begin
                    state <= ils_pkg::S_PUT;
                  end else begin
                    rptr  <= ils_pkg::ADDR_W'(cnt_ext - ils_pkg::CMP_W'(1));
                    last  <= ils_pkg::ADDR_W'(ins_pos);
                    state <= ils_pkg::S_SHIFT;
                  end
                end
              end
              ils_pkg::OP_DELETE: begin
                if (pos_ext >= cnt_ext) begin
                  status <= ils_pkg::ST_RANGE;
                  done   <= 1'b1;
                end else if (pos_ext == cnt_ext - ils_pkg::CMP_W'(1)) begin
                  count <= count - ils_pkg::CNT_W'(1);
                  done  <= 1'b1;
                end else begin
                  is_ins <= 1'b0;
                  rptr   <= ils_pkg::ADDR_W'(pos_ext + ils_pkg::CMP_W'(1));
                  last   <= ils_pkg::ADDR_W'(cnt_ext - ils_pkg::CMP_W'(1));
                  state  <= ils_pkg::S_SHIFT;
                end
              end
              default: begin
                status <= ils_pkg::ST_RANGE;
                done   <= 1'b1;
              end
            endcase
          end
        end
        ils_pkg::S_RDWAIT: begin
          read_value <= rdata;
          done       <= 1'b1;
          state      <= ils_pkg::S_IDLE;
        end
        ils_pkg::S_SHIFT: begin
          if (is_ins) begin
            wr_addr <= rptr + ils_pkg::ADDR_W'(1);
          end else begin
            wr_addr <= rptr - ils_pkg::ADDR_W'(1);
          end
          if (rptr == last) begin
            state <= ils_pkg::S_DRAIN;
          end else if (is_ins) begin
            rptr <= rptr - ils_pkg::ADDR_W'(1);
          end else begin
            rptr <= rptr + ils_pkg::ADDR_W'(1);
          end
        end
        ils_pkg::S_DRAIN: begin
          if (is_ins) begin
            state <= ils_pkg::S_PUT;
          end else begin
            count <= count - ils_pkg::CNT_W'(1);
            done  <= 1'b1;
            state <= ils_pkg::S_IDLE;
          end
        end
        ils_pkg::S_PUT: begin
          count <= count + ils_pkg::CNT_W'(1);
          done  <= 1'b1;
          state <= ils_pkg::S_IDLE;
        end
        default: begin
          state <= ils_pkg::S_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt_ext <= ils_pkg::CMP_W'(ils_pkg::CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_accept_progress: assert property (@(posedge clk) disable iff (rst)
    accept |=> (busy || done))
    else $error("Accepted transaction neither started nor finished.");

  a_shift_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == ils_pkg::S_SHIFT) |-> (count != '0))
    else $error("Entry move running on an empty list.");

  a_put_port_free: assert property (@(posedge clk) disable iff (rst)
    (state == ils_pkg::S_PUT) |-> !wr_pend)
    else $error("Value write collides with a pending move write.");
`endif

endmodule
